// ===== sv/ialist_pkg.sv =====
// Shared types and constants for the indexed array list engine.
// Used by the list cell and by the core top level; depends on nothing.
package ialist_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    // operation kinds
    localparam logic [2:0] K_PUSH      = 3'd0;
    localparam logic [2:0] K_INSERT    = 3'd1;
    localparam logic [2:0] K_POP       = 3'd2;
    localparam logic [2:0] K_REMOVE    = 3'd3;
    localparam logic [2:0] K_READ      = 3'd4;
    localparam logic [2:0] K_OVERWRITE = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // cell update modes
    localparam logic [1:0] CM_HOLD  = 2'd0;
    localparam logic [1:0] CM_WRITE = 2'd1;
    localparam logic [1:0] CM_INS   = 2'd2;
    localparam logic [1:0] CM_DEL   = 2'd3;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  sel;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  rd_sel;
    } t_cell_ctrl;

endpackage

// ===== sv/ialist_cell.sv =====
// One cell of the list row: holds a single entry and trades it with its neighbors.
// Depends on ialist_pkg for the control struct and the cell update modes.
module ialist_cell #(
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  ialist_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ialist_pkg::WORD_W-1:0] i_lower,
    input  logic [ialist_pkg::WORD_W-1:0] i_upper,
    output logic [ialist_pkg::WORD_W-1:0] o_data,
    output logic [ialist_pkg::WORD_W-1:0] o_tap
);
    import ialist_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    // pick the next entry: keep, take the new word, or shift from a neighbor
    always_comb begin
        n_data = r_data;
        case (i_ctrl.mode)
            CM_WRITE: begin
                if (MY_IDX == i_ctrl.sel) n_data = i_ctrl.word;
            end
            CM_INS: begin
                if (MY_IDX == i_ctrl.sel) n_data = i_ctrl.word;
                else if (MY_IDX > i_ctrl.sel) n_data = i_lower;
            end
            CM_DEL: begin
                if (MY_IDX >= i_ctrl.sel) n_data = i_upper;
            end
            default: n_data = r_data;
        endcase
    end

    // entry storage, no reset: read only after written
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // drive the read tap only when this cell is addressed
    assign o_tap  = (MY_IDX == i_ctrl.rd_sel) ? r_data : '0;

endmodule

// ===== sv/indexed_array_list_engine_core.sv =====
// Indexed array list engine: ordered list of signed 32-bit words in a row of cells.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the input is not stalled; the selected cells shift or write in the accept cycle.
// Input is stalled only while a finished result waits and the output is stalled.
// Reset clears the entry count and the output valid; cell contents are not cleared.
module indexed_array_list_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_kind,
    input  logic [5:0]                    i_position,
    input  logic signed [31:0]            i_word_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_word_out,
    output logic [1:0]                    o_status,
    output logic [6:0]                    o_entry_count,
    output logic                          o_is_empty
);
    import ialist_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word_out;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_entry_count;
    logic              r_is_empty;

    logic              accept;
    logic [CNT_W-1:0]  pos_ext;
    logic [1:0]        status;
    logic              rd_en;
    logic [1:0]        mode;
    logic [IDX_W-1:0]  sel;
    logic [IDX_W-1:0]  rd_sel;
    logic [WORD_W-1:0] rd_or;
    t_cell_ctrl        ctrl;

    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [WORD_W-1:0] cell_tap  [CAPACITY];

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign pos_ext    = CNT_W'(i_position);

    // decode the operation, check bounds, set the cell mode and next count
    always_comb begin
        status  = ST_OK;
        rd_en   = 1'b0;
        mode    = CM_HOLD;
        sel     = i_position;
        rd_sel  = i_position;
        n_count = r_count;
        case (i_kind)
            K_PUSH: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    mode    = CM_WRITE;
                    sel     = r_count[IDX_W-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            K_INSERT: begin
                if (pos_ext > r_count) begin
                    status = ST_BAD_INDEX;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    mode    = CM_INS;
                    n_count = r_count + 1'b1;
                end
            end
            K_POP: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    rd_sel  = n_count[IDX_W-1:0];
                    rd_en   = 1'b1;
                end
            end
            K_REMOVE: begin
                if (pos_ext >= r_count) begin
                    status = ST_BAD_INDEX;
                end else begin
                    mode    = CM_DEL;
                    n_count = r_count - 1'b1;
                end
            end
            K_READ: begin
                if (pos_ext >= r_count) status = ST_BAD_INDEX;
                else rd_en = 1'b1;
            end
            K_OVERWRITE: begin
                if (pos_ext >= r_count) status = ST_BAD_INDEX;
                else mode = CM_WRITE;
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // broadcast control; cells hold unless an item is accepted
    always_comb begin
        ctrl.mode   = accept ? mode : CM_HOLD;
        ctrl.sel    = sel;
        ctrl.word   = i_word_in;
        ctrl.rd_sel = rd_sel;
    end

    // row of cells, each linked to its lower and upper neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] upper;
        if (g == 0) begin : g_lo_edge
            assign lower = '0;
        end else begin : g_lo
            assign lower = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi_edge
            assign upper = '0;
        end else begin : g_hi
            assign upper = cell_data[g+1];
        end
        ialist_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // combine the read taps; only the addressed cell drives nonzero
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_tap[k];
        end
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) r_count <= n_count;
            if (accept) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded on accept and held while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word_out    <= rd_en ? rd_or : '0;
            r_status      <= status;
            r_entry_count <= n_count;
            r_is_empty    <= (n_count == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_out    = r_word_out;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;

endmodule

// ===== tb/sv/indexed_array_list_engine_core_tb.sv =====
// Self-checking testbench for the indexed array list engine core.
// Uses ialist_pkg and the core RTL. A built-in list predictor supplies the expected
// results, and directed plus random operations run under several idle profiles.
module indexed_array_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ialist_pkg::*;

    // kinds the block ignores
    localparam logic [2:0] K_UNUSED_A = 3'd6;
    localparam logic [2:0] K_UNUSED_B = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 560;

    typedef struct packed {
        logic signed [31:0] word;
        logic [1:0]         status;
        logic [6:0]         count;
        logic               empty;
    } t_list_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind        = '0;
    logic [5:0]         i_position    = '0;
    logic signed [31:0] i_word_in     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic signed [31:0] o_word_out;
    logic [1:0]         o_status;
    logic [6:0]         o_entry_count;
    logic               o_is_empty;

    // predicted list contents and length
    logic signed [31:0] list_mem [CAPACITY];
    int                 list_len = 0;

    t_list_result expected_results_q [$];
    t_list_result want;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int errors          = 0;
    int idle_cycles     = 0;

    indexed_array_list_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_word_in     (i_word_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_word_out    (o_word_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the predicted list and return the expected result.
    function automatic t_list_result apply_list_op(input logic [2:0] kind,
                                                   input logic [5:0] pos,
                                                   input logic signed [31:0] word);
        t_list_result res;
        int           i;
        res.word   = '0;
        res.status = ST_OK;
        case (kind)
            K_PUSH: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = word;
                    list_len++;
                end
            end
            K_INSERT: begin
                if (int'(pos) > list_len) begin
                    res.status = ST_BAD_INDEX;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > int'(pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = word;
                    list_len++;
                end
            end
            K_POP: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    list_len--;
                    res.word = list_mem[list_len];
                end
            end
            K_REMOVE: begin
                if (int'(pos) >= list_len) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            K_READ: begin
                if (int'(pos) >= list_len)
                    res.status = ST_BAD_INDEX;
                else
                    res.word = list_mem[pos];
            end
            K_OVERWRITE: begin
                if (int'(pos) >= list_len)
                    res.status = ST_BAD_INDEX;
                else
                    list_mem[pos] = word;
            end
            default: begin
            end
        endcase
        res.count = list_len[6:0];
        res.empty = (list_len == 0);
        return res;
    endfunction

    // Offer one item, hold it until accepted, then record its expected result.
    task automatic send_item(input logic [2:0] kind, input logic [5:0] pos,
                             input logic signed [31:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_word_in  <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results_q.push_back(apply_list_op(kind, pos, word));
        items_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_results_drained;
        i_in_valid <= 1'b0;
        while (expected_results_q.size() != 0) @(posedge i_clk);
    endtask

    // Pick an index: mostly in range for the operation, sometimes anywhere.
    function automatic logic [5:0] pick_position(input bit for_insert);
        if ($urandom_range(9) == 0)
            return 6'($urandom_range(63));
        if (for_insert)
            return 6'($urandom_range(list_len > 63 ? 63 : list_len));
        if (list_len == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(list_len - 1));
    endfunction

    // Pick a data word, with the signed extremes now and then.
    function automatic logic signed [31:0] pick_word;
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Every operation except push on an empty list, plus the unused kinds.
    task automatic test_empty_list;
        send_item(K_POP, 6'd0, 32'sd0);
        send_item(K_READ, 6'd0, 32'sd0);
        send_item(K_READ, 6'd63, 32'sd0);
        send_item(K_REMOVE, 6'd0, 32'sd0);
        send_item(K_OVERWRITE, 6'd5, 32'sh1234_5678);
        send_item(K_INSERT, 6'd1, 32'sh0bad_0bad);
        send_item(K_UNUSED_A, 6'd63, 32'shffff_ffff);
        send_item(K_UNUSED_B, 6'd0, 32'sh8000_0000);
    endtask

    // Short directed sequence over each operation and the index edges.
    task automatic test_basic_ops;
        send_item(K_PUSH, 6'd63, 32'sh8000_0000);
        send_item(K_PUSH, 6'd0, 32'sh7fff_ffff);
        send_item(K_INSERT, 6'd0, -32'sd1);
        send_item(K_INSERT, 6'd3, 32'sd0);
        send_item(K_INSERT, 6'd5, 32'sd7);
        send_item(K_READ, 6'd0, 32'sd0);
        send_item(K_READ, 6'd3, 32'sd0);
        send_item(K_OVERWRITE, 6'd2, 32'sh5555_5555);
        send_item(K_READ, 6'd2, 32'sd0);
        send_item(K_READ, 6'd4, 32'sd0);
        send_item(K_REMOVE, 6'd0, 32'sd0);
        send_item(K_REMOVE, 6'd2, 32'sd0);
        send_item(K_POP, 6'd0, 32'sd0);
        send_item(K_POP, 6'd0, 32'sd0);
        send_item(K_POP, 6'd0, 32'sd0);
    endtask

    // Fill to capacity, hit the full cases, pause until idle, then empty out.
    task automatic test_full_list;
        while (list_len < CAPACITY) send_item(K_PUSH, 6'($urandom_range(63)), pick_word());
        send_item(K_PUSH, 6'd0, pick_word());
        send_item(K_INSERT, 6'd0, pick_word());
        send_item(K_INSERT, 6'(CAPACITY - 1), pick_word());
        send_item(K_OVERWRITE, 6'(CAPACITY - 1), pick_word());
        send_item(K_READ, 6'(CAPACITY - 1), 32'sd0);
        send_item(K_READ, 6'd0, 32'sd0);
        wait_results_drained();
        repeat (16) send_item(K_REMOVE, 6'($urandom_range(list_len - 1)), pick_word());
        while (list_len > 0) send_item(K_POP, 6'($urandom_range(63)), pick_word());
        send_item(K_POP, 6'($urandom_range(63)), pick_word());
    endtask

    // Random operation mix that sweeps the list up and down between random marks.
    task automatic test_random_ops(input int n_items, input int send_pct, input int recv_pct);
        int              i;
        int              r;
        int              hi_mark;
        int              lo_mark;
        bit              grow;
        logic [2:0]      kind;
        logic [5:0]      pos;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        grow    = 1'b1;
        hi_mark = $urandom_range(8, CAPACITY);
        lo_mark = 0;
        for (i = 0; i < n_items; i++) begin
            if (grow && list_len >= hi_mark) begin
                grow    = 1'b0;
                lo_mark = $urandom_range(8);
            end else if (!grow && list_len <= lo_mark) begin
                grow    = 1'b1;
                hi_mark = ($urandom_range(3) == 0) ? CAPACITY : $urandom_range(8, CAPACITY);
            end
            r = $urandom_range(99);
            if (r < 4)
                kind = 3'($urandom_range(7));
            else if (r < 40)
                kind = grow ? K_PUSH : K_POP;
            else if (r < 62)
                kind = grow ? K_INSERT : K_REMOVE;
            else if (r < 70)
                kind = grow ? K_POP : K_PUSH;
            else if (r < 76)
                kind = grow ? K_REMOVE : K_INSERT;
            else if (r < 90)
                kind = K_READ;
            else
                kind = K_OVERWRITE;
            pos = (r < 4) ? 6'($urandom_range(63)) : pick_position(kind == K_INSERT);
            send_item(kind, pos, pick_word());
            // pause the sender once per phase until the block is idle
            if (i == n_items / 2)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Randomize the output stall each cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results_q.size() == 0) begin
                $error("result with no expectation: word_out %0d status %0d count %0d",
                       o_word_out, o_status, o_entry_count);
                errors++;
            end else begin
                want = expected_results_q.pop_front();
                results_checked++;
                if (o_word_out !== want.word) begin
                    $error("word_out mismatch: expected %0d, got %0d", want.word, o_word_out);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.count, o_entry_count);
                    errors++;
                end
                if (o_is_empty !== want.empty) begin
                    $error("is_empty mismatch: expected %0d, got %0d", want.empty, o_is_empty);
                    errors++;
                end
            end
        end
    end

    // End the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 49;
        test_empty_list();
        test_basic_ops();
        test_random_ops(RANDOM_ITEMS, 22, 49);
        test_full_list();
        test_random_ops(RANDOM_ITEMS, 49, 22);
        test_random_ops(RANDOM_ITEMS, 0, 0);

        // let any stray result show up before the verdict
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d list operations and checked %0d results under three idle mixes,",
                 items_sent, results_checked);
        $display("with empty and full lists, bad indexes, signed extremes and unused kinds.");
        if (errors == 0 && expected_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never seen", errors, expected_results_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
